FILE: sv/brm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brm_pkg
// Shared types and codes of the banker's resource manager.
// ----------------------------------------------------------------------------
package brm_pkg;

	localparam int AMT_W    = 8;
	localparam int MAX_RES  = 4;
	localparam int RES_DEF  = 3;
	localparam int CUST_DEF = 5;
	// work vector: avail + up to 16 allocations + one tentative grant, < 2^13
	localparam int WORK_W   = 13;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SAFE,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		CMD_REQUEST,
		CMD_RELEASE,
		CMD_DECLARE,
		CMD_RESTART
	} cmd_t;

	localparam logic [2:0] STAT_GRANTED = 3'd0;
	localparam logic [2:0] STAT_NEED    = 3'd1;
	localparam logic [2:0] STAT_AVAIL   = 3'd2;
	localparam logic [2:0] STAT_UNSAFE  = 3'd3;
	localparam logic [2:0] STAT_RELEASE = 3'd4;
	localparam logic [2:0] STAT_DONE    = 3'd5;

	localparam logic [1:0] REG_TOTAL0 = 2'd0;
	localparam logic [1:0] REG_TOTAL1 = 2'd1;
	localparam logic [1:0] REG_TOTAL2 = 2'd2;
	localparam logic [1:0] REG_TOTAL3 = 2'd3;

	function automatic logic [AMT_W-1:0] sat_add(input logic [AMT_W-1:0] a,
		input logic [AMT_W-1:0] b);
		logic [AMT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AMT_W] ? {AMT_W{1'b1}} : s[AMT_W-1:0];
	endfunction

endpackage

FILE: sv/brm_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brm_table
// Per-customer allocation/need memory, registered read, per-entry
// valid bits so that unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module brm_table
	import brm_pkg::*;
#(
	parameter int CUSTOMERS = CUST_DEF,
	parameter int WIDTH     = 2 * RES_DEF * AMT_W,
	localparam int AW       = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0]     mem [CUSTOMERS];
	logic [CUSTOMERS-1:0] vld_q;
	logic [WIDTH-1:0]     rd_s1;
	logic                 hit_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			hit_s1 <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			hit_s1 <= (32'(raddr) < CUSTOMERS) ? vld_q[raddr] : 1'b0;
		end
	end

	assign rdata = hit_s1 ? rd_s1 : '0;

endmodule

FILE: sv/bankers_resource_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_resource_manager_unit
// Banker's algorithm resource manager with sequential safety scan.
// ----------------------------------------------------------------------------
// One request in, one response out. Commands: request, release, declare need,
// restart (reload availability from the total registers, clear all tables).
// Allocation and remaining need of each customer live in one memory entry;
// availability is a small register vector. Release, declare, restart and any
// refused check pass from accept to response through memory read, decide and
// response register. A request that passes the need and availability checks
// runs the safety scan: the memory is streamed one customer per cycle in
// passes until a pass finishes no new customer. A new request is taken once
// the previous one has reached the response register, even if that response
// is still waiting on m_tready. Total registers are written over the cfg
// channel (always ready) and used only by restart.
// ----------------------------------------------------------------------------
module bankers_resource_manager_unit
	import brm_pkg::*;
#(
	parameter int RESOURCES = RES_DEF,
	parameter int CUSTOMERS = CUST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // customer[3:0], amount_0..amount_3, 8 b each
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // status[2:0], avail_0..avail_3, 8 b each, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int AW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
	localparam int VW = RESOURCES * AMT_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(CUSTOMERS - 1);

	state_t state_q, state_d;

	logic [MAX_RES-1:0][AMT_W-1:0]   total_q;
	logic [RESOURCES-1:0][AMT_W-1:0] avail_q;
	cmd_t                            cmd_q;
	logic [3:0]                      cust_q;
	logic [RESOURCES-1:0][AMT_W-1:0] amt_q;
	logic [2*VW-1:0]                 ent_q;   // requester's entry, kept for commit
	logic [2:0]                      status_q;

	// safety scan
	logic [RESOURCES-1:0][WORK_W-1:0] work_q;
	logic [CUSTOMERS-1:0]             fin_q;
	logic                             prog_q;
	logic [AW-1:0]                    rd_idx_q;
	logic                             ev_vld_s1;
	logic [AW-1:0]                    ev_idx_s1;

	logic            m_tvalid_q;
	logic [39:0]     m_tdata_q;
	logic [39:0]     resp_data;

	// memory port
	logic            mem_we, mem_clr;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [2*VW-1:0] mem_wdata, mem_rdata;

	logic [AW-1:0]   cust_idx;
	logic            cust_ok;
	logic            accept;
	logic            resp_free;

	logic [RESOURCES-1:0][AMT_W-1:0] rd_alloc, rd_need;
	logic [RESOURCES-1:0][AMT_W-1:0] ent_alloc, ent_need;
	logic [RESOURCES-1:0][AMT_W-1:0] rel_alloc, rel_need, gr_alloc, gr_need;
	logic need_bad, avail_bad, rel_bad;

	logic [RESOURCES-1:0][AMT_W:0]   e_alloc;
	logic [RESOURCES-1:0][AMT_W-1:0] e_need;
	logic                            fits, take, pass_end, scan_done, scan_safe;
	logic [CUSTOMERS-1:0]            fin_next;

	assign cust_idx  = cust_q[AW-1:0];
	assign cust_ok   = 32'(cust_q) < CUSTOMERS;
	assign accept    = s_tvalid && s_tready;
	assign resp_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	brm_table #(
		.CUSTOMERS (CUSTOMERS),
		.WIDTH     (2 * VW)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	// entry layout: {need, alloc}
	assign rd_alloc  = mem_rdata[VW-1:0];
	assign rd_need   = mem_rdata[2*VW-1:VW];
	assign ent_alloc = ent_q[VW-1:0];
	assign ent_need  = ent_q[2*VW-1:VW];

	// per-type checks and updated entries
	always_comb begin
		need_bad  = 1'b0;
		avail_bad = 1'b0;
		rel_bad   = 1'b0;
		for (int r = 0; r < RESOURCES; r++) begin
			need_bad     = need_bad  | (amt_q[r] > rd_need[r]);
			avail_bad    = avail_bad | (amt_q[r] > avail_q[r]);
			rel_bad      = rel_bad   | (amt_q[r] > rd_alloc[r]);
			rel_alloc[r] = rd_alloc[r] - amt_q[r];
			rel_need[r]  = sat_add(rd_need[r], amt_q[r]);
			gr_alloc[r]  = sat_add(ent_alloc[r], amt_q[r]);
			gr_need[r]   = ent_need[r] - amt_q[r];
		end
	end

	// safety scan evaluation; the requester is seen with the grant applied
	always_comb begin
		fits = 1'b1;
		for (int r = 0; r < RESOURCES; r++) begin
			if (ev_idx_s1 == cust_idx) begin
				e_alloc[r] = {1'b0, rd_alloc[r]} + {1'b0, amt_q[r]};
				e_need[r]  = rd_need[r] - amt_q[r];
			end else begin
				e_alloc[r] = {1'b0, rd_alloc[r]};
				e_need[r]  = rd_need[r];
			end
			fits = fits & (work_q[r] >= WORK_W'(e_need[r]));
		end
		take      = ev_vld_s1 && !fin_q[ev_idx_s1] && fits;
		fin_next  = fin_q | (CUSTOMERS'(take) << ev_idx_s1);
		pass_end  = ev_vld_s1 && (ev_idx_s1 == LAST_IDX);
		scan_done = pass_end && !(prog_q || take);
		scan_safe = &fin_next;
	end

	// response word: status low, then availability per type, zero padded
	always_comb begin
		resp_data      = '0;
		resp_data[2:0] = status_q;
		for (int r = 0; r < RESOURCES; r++)
			resp_data[3 + AMT_W*r +: AMT_W] = avail_q[r];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (cmd_q == CMD_REQUEST && cust_ok && !need_bad && !avail_bad)
					state_d = ST_SAFE;
				else
					state_d = ST_RESP;
			end
			ST_SAFE: begin
				if (scan_done) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (resp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		mem_we    = 1'b0;
		mem_clr   = 1'b0;
		mem_waddr = cust_idx;
		mem_wdata = {rel_need, rel_alloc};
		mem_raddr = (state_q == ST_IDLE) ? s_tdata[AW-1:0] : rd_idx_q;
		unique case (state_q)
			ST_CHECK: begin
				unique case (cmd_q)
					CMD_RELEASE: mem_we = cust_ok && !rel_bad;
					CMD_DECLARE: begin
						mem_we    = cust_ok;
						mem_wdata = {amt_q, rd_alloc};
					end
					CMD_RESTART: mem_clr = 1'b1;
					CMD_REQUEST: mem_we = 1'b0;
					default:     mem_we = 1'b0;
				endcase
			end
			ST_SAFE: begin
				mem_we    = scan_done && scan_safe;
				mem_wdata = {gr_need, gr_alloc};
			end
			ST_IDLE, ST_RESP: mem_we = 1'b0;
			default:          mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			avail_q    <= '0;
			m_tvalid_q <= 1'b0;
			ev_vld_s1  <= 1'b0;
			fin_q      <= '0;
			prog_q     <= 1'b0;
			rd_idx_q   <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TOTAL0: total_q[0] <= cfg_data;
					REG_TOTAL1: total_q[1] <= cfg_data;
					REG_TOTAL2: total_q[2] <= cfg_data;
					REG_TOTAL3: total_q[3] <= cfg_data;
					default:    total_q[0] <= cfg_data;
				endcase
			end

			// load a fresh response, else drop the one taken downstream
			if (state_q == ST_RESP && resp_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_CHECK: begin
					ev_vld_s1 <= 1'b0;
					fin_q     <= '0;
					prog_q    <= 1'b0;
					rd_idx_q  <= '0;
					for (int r = 0; r < RESOURCES; r++) begin
						work_q[r] <= WORK_W'(avail_q[r] - amt_q[r]);
						if (cmd_q == CMD_RELEASE && cust_ok && !rel_bad)
							avail_q[r] <= sat_add(avail_q[r], amt_q[r]);
						if (cmd_q == CMD_RESTART)
							avail_q[r] <= total_q[r];
					end
				end
				ST_SAFE: begin
					ev_vld_s1 <= !scan_done;
					rd_idx_q  <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
					fin_q     <= fin_next;
					if (take) begin
						for (int r = 0; r < RESOURCES; r++)
							work_q[r] <= work_q[r] + WORK_W'(e_alloc[r]);
					end
					if (pass_end) prog_q <= 1'b0;
					else if (take) prog_q <= 1'b1;
					if (scan_done && scan_safe) begin
						for (int r = 0; r < RESOURCES; r++)
							avail_q[r] <= avail_q[r] - amt_q[r];
					end
				end
				ST_RESP: ev_vld_s1 <= 1'b0;
				ST_IDLE: ev_vld_s1 <= 1'b0;
				default: ev_vld_s1 <= 1'b0;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(s_tuser);
			cust_q <= s_tdata[3:0];
			for (int r = 0; r < RESOURCES; r++)
				amt_q[r] <= s_tdata[4 + AMT_W*r +: AMT_W];
		end
		ev_idx_s1 <= rd_idx_q;
		if (state_q == ST_CHECK) begin
			ent_q <= mem_rdata;
			priority if (cmd_q == CMD_REQUEST) begin
				status_q <= (!cust_ok || need_bad) ? STAT_NEED : STAT_AVAIL;
			end else if (cmd_q == CMD_RELEASE) begin
				status_q <= (!cust_ok || rel_bad) ? STAT_RELEASE : STAT_DONE;
			end else begin
				status_q <= STAT_DONE;
			end
		end
		if (state_q == ST_SAFE && scan_done)
			status_q <= scan_safe ? STAT_GRANTED : STAT_UNSAFE;
		if (state_q == ST_RESP && resp_free)
			m_tdata_q <= resp_data;
	end

	// scan pipeline runs only inside the safety scan
	a_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		ev_vld_s1 |-> state_q == ST_SAFE)
		else $error("scan data valid outside safety scan");

	// a customer marked finished stays finished for the rest of the scan
	a_fin_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SAFE && $past(state_q) == ST_SAFE) |->
		((fin_q & $past(fin_q)) == $past(fin_q)))
		else $error("finished customer lost during scan");

	// a grant is only answered after every customer could finish
	a_grant_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && status_q == STAT_GRANTED) |-> &fin_q)
		else $error("grant without safe state");

endmodule

FILE: bench/bankers_resource_manager_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_resource_manager_unit_tb
// Self-checking bench for the banker's resource manager.
// ----------------------------------------------------------------------------
// An in-bench banker's predictor tracks availability, allocation and need.
// Directed cases cover every command, every status code, saturation and
// out-of-range customers. Random phases then run with several total settings.
// Both stream sides idle at random, and one phase holds off the response side
// so the block backs up. Every response is checked field by field against the
// oldest expected response.
// ----------------------------------------------------------------------------
module bankers_resource_manager_unit_tb;
	import brm_pkg::*;

	localparam int NRES  = 3;
	localparam int NCUST = 5;
	localparam int WDOG_LIMIT = 3000;

	typedef struct {
		logic [2:0]      status;
		logic [3:0][7:0] avail;
	} resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = CMD_REQUEST;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_TOTAL0;
	logic [7:0]  cfg_data = '0;

	bankers_resource_manager_unit u_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// banker's state mirror
	logic [7:0] totals [4];
	logic [7:0] avail_units [NRES];
	logic [7:0] alloc_units [NCUST][NRES];
	logic [7:0] need_units  [NCUST][NRES];

	resp_t resp_q [$];
	int    errors = 0;
	int    rx_wait = 0;
	bit    rx_hold = 1'b0;
	bit    no_idle = 1'b0;
	int    quiet_cycles = 0;

	task automatic report(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// tentative grant of amt to cust, then finish customers while any fits
	function automatic bit grant_is_safe(int cust, logic [3:0][7:0] amt);
		int work [NRES];
		int al [NCUST][NRES];
		int nd [NCUST][NRES];
		bit done [NCUST];
		bit moved;
		bit fits;
		for (int c = 0; c < NCUST; c++) begin
			done[c] = 1'b0;
			for (int r = 0; r < NRES; r++) begin
				al[c][r] = alloc_units[c][r];
				nd[c][r] = need_units[c][r];
			end
		end
		for (int r = 0; r < NRES; r++) begin
			work[r] = int'(avail_units[r]) - int'(amt[r]);
			al[cust][r] += amt[r];
			nd[cust][r] -= amt[r];
		end
		moved = 1'b1;
		while (moved) begin
			moved = 1'b0;
			for (int c = 0; c < NCUST; c++) begin
				if (!done[c]) begin
					fits = 1'b1;
					for (int r = 0; r < NRES; r++)
						if (work[r] < nd[c][r]) fits = 1'b0;
					if (fits) begin
						done[c] = 1'b1;
						moved = 1'b1;
						for (int r = 0; r < NRES; r++) work[r] += al[c][r];
					end
				end
			end
		end
		for (int c = 0; c < NCUST; c++)
			if (!done[c]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] sat8(int v);
		return (v > 255) ? 8'hFF : v[7:0];
	endfunction

	// apply one command to the mirror and return the expected response
	function automatic resp_t banker_step(cmd_t cmd, int cust, logic [3:0][7:0] amt);
		resp_t rsp;
		bit bad;
		rsp.status = STAT_DONE;
		case (cmd)
			CMD_REQUEST: begin
				bad = (cust >= NCUST);
				if (!bad)
					for (int r = 0; r < NRES; r++)
						if (amt[r] > need_units[cust][r]) bad = 1'b1;
				if (bad) rsp.status = STAT_NEED;
				else begin
					for (int r = 0; r < NRES; r++)
						if (amt[r] > avail_units[r]) bad = 1'b1;
					if (bad) rsp.status = STAT_AVAIL;
					else if (!grant_is_safe(cust, amt)) rsp.status = STAT_UNSAFE;
					else begin
						rsp.status = STAT_GRANTED;
						for (int r = 0; r < NRES; r++) begin
							avail_units[r] -= amt[r];
							alloc_units[cust][r] = sat8(alloc_units[cust][r] + amt[r]);
							need_units[cust][r] -= amt[r];
						end
					end
				end
			end
			CMD_RELEASE: begin
				bad = (cust >= NCUST);
				if (!bad)
					for (int r = 0; r < NRES; r++)
						if (amt[r] > alloc_units[cust][r]) bad = 1'b1;
				if (bad) rsp.status = STAT_RELEASE;
				else
					for (int r = 0; r < NRES; r++) begin
						avail_units[r] = sat8(avail_units[r] + amt[r]);
						alloc_units[cust][r] -= amt[r];
						need_units[cust][r] = sat8(need_units[cust][r] + amt[r]);
					end
			end
			CMD_DECLARE: begin
				if (cust < NCUST)
					for (int r = 0; r < NRES; r++) need_units[cust][r] = amt[r];
			end
			default: begin
				for (int r = 0; r < NRES; r++) avail_units[r] = totals[r];
				for (int c = 0; c < NCUST; c++)
					for (int r = 0; r < NRES; r++) begin
						alloc_units[c][r] = '0;
						need_units[c][r] = '0;
					end
			end
		endcase
		rsp.avail = '0;
		for (int r = 0; r < NRES; r++) rsp.avail[r] = avail_units[r];
		return rsp;
	endfunction

	// send one request; called and left at a falling edge
	task automatic send_request(cmd_t cmd, int cust, logic [3:0][7:0] amt);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  = cmd;
		s_tdata  = {4'b0, amt[3], amt[2], amt[1], amt[0], cust[3:0]};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		resp_q.push_back(banker_step(cmd, cust, amt));
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (resp_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_total(logic [1:0] idx, logic [7:0] val);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		totals[idx] = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_totals(logic [7:0] t0, logic [7:0] t1, logic [7:0] t2,
		logic [7:0] t3);
		write_total(REG_TOTAL0, t0);
		write_total(REG_TOTAL1, t1);
		write_total(REG_TOTAL2, t2);
		write_total(REG_TOTAL3, t3);
	endtask

	function automatic logic [3:0][7:0] amts(int a0, int a1, int a2, int a3);
		return {a3[7:0], a2[7:0], a1[7:0], a0[7:0]};
	endfunction

	// response side: random stalls, pause windows, and result checks
	always @(negedge clk) begin
		if (rx_hold) m_tready = 1'b0;
		else if (rx_wait > 0) begin
			m_tready = 1'b0;
			rx_wait--;
		end else m_tready = 1'b1;
	end

	always @(posedge clk) begin
		resp_t want;
		if (m_tvalid && m_tready) begin
			rx_wait = no_idle ? 0 : $urandom_range(0, 16);
			if (resp_q.size() == 0) report("unexpected response", m_tdata[2:0], -1);
			else begin
				want = resp_q.pop_front();
				if (m_tdata[2:0] != want.status) report("status", m_tdata[2:0], want.status);
				for (int r = 0; r < 4; r++)
					if (m_tdata[3 + 8*r +: 8] != want.avail[r])
						report($sformatf("avail_%0d", r), m_tdata[3 + 8*r +: 8],
							want.avail[r]);
			end
		end
	end

	// watchdog on cycles without any accepted transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("bankers_resource_manager_unit_tb failed");
			$finish;
		end
	end

	// state right after reset: all zero, nothing to grant
	task automatic test_reset_state();
		send_request(CMD_REQUEST, 0, amts(0, 0, 0, 0));
		send_request(CMD_REQUEST, 1, amts(1, 0, 0, 0));
		send_request(CMD_RESTART, 0, amts(0, 0, 0, 0));
		drain();
	endtask

	task automatic test_directed();
		set_totals(10, 10, 10, 8'hA5);
		send_request(CMD_RESTART, 9, amts(255, 255, 255, 255));
		send_request(CMD_DECLARE, 0, amts(8, 0, 0, 0));
		send_request(CMD_DECLARE, 1, amts(8, 0, 0, 0));
		send_request(CMD_REQUEST, 0, amts(9, 0, 0, 0));      // beyond need
		send_request(CMD_REQUEST, 0, amts(5, 0, 0, 255));    // granted, type 3 ignored
		send_request(CMD_REQUEST, 1, amts(5, 0, 0, 0));      // leaves no safe order
		send_request(CMD_REQUEST, 1, amts(6, 0, 0, 0));      // beyond available
		send_request(CMD_RELEASE, 0, amts(6, 0, 0, 0));      // beyond allocation
		send_request(CMD_RELEASE, 0, amts(5, 0, 0, 0));
		send_request(CMD_REQUEST, 7, amts(0, 0, 0, 0));      // customers out of range
		send_request(CMD_RELEASE, 15, amts(0, 0, 0, 0));
		send_request(CMD_DECLARE, 5, amts(1, 2, 3, 4));
		drain();
		// saturation of availability and need on release
		set_totals(255, 255, 255, 255);
		send_request(CMD_RESTART, 0, amts(0, 0, 0, 0));
		send_request(CMD_DECLARE, 4, amts(255, 255, 255, 255));
		send_request(CMD_REQUEST, 4, amts(10, 255, 1, 0));
		send_request(CMD_DECLARE, 4, amts(255, 255, 255, 0));
		send_request(CMD_RELEASE, 4, amts(10, 255, 1, 0));
		send_request(CMD_RELEASE, 4, amts(0, 0, 0, 255));
		drain();
	endtask

	// mostly well-formed traffic shaped by the mirrored tables
	task automatic run_random(int n);
		int sel;
		int cust;
		int noise;
		logic [3:0][7:0] amt;
		for (int i = 0; i < n; i++) begin
			if ((i % 64) == 0) no_idle = ($urandom_range(0, 3) == 0);
			sel   = $urandom_range(0, 99);
			cust  = ($urandom_range(0, 19) == 0) ? $urandom_range(NCUST, 15)
				: $urandom_range(0, NCUST - 1);
			noise = ($urandom_range(0, 9) == 0);
			amt   = '0;
			amt[3] = 8'($urandom);
			for (int r = 0; r < NRES; r++) begin
				if (noise) amt[r] = 8'($urandom);
				else if (sel < 20) amt[r] = 8'($urandom_range(0, totals[r]));
				else if (cust >= NCUST) amt[r] = 8'($urandom_range(0, 7));
				else if (sel < 65) amt[r] = 8'($urandom_range(0, need_units[cust][r]));
				else amt[r] = 8'($urandom_range(0, alloc_units[cust][r]));
			end
			if (sel < 3) send_request(CMD_RESTART, $urandom_range(0, 15), amt);
			else if (sel < 20) send_request(CMD_DECLARE, cust, amt);
			else if (sel < 65) send_request(CMD_REQUEST, cust, amt);
			else send_request(CMD_RELEASE, cust, amt);
		end
		no_idle = 1'b0;
		drain();
	endtask

	task automatic test_random_phases();
		set_totals(0, 0, 0, 0);
		send_request(CMD_RESTART, 0, amts(0, 0, 0, 0));
		run_random(150);
		set_totals(255, 255, 255, 255);
		send_request(CMD_RESTART, 0, amts(0, 0, 0, 0));
		run_random(450);
		set_totals(4, 6, 3, 1);
		send_request(CMD_RESTART, 0, amts(0, 0, 0, 0));
		run_random(450);
		set_totals(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		send_request(CMD_RESTART, 0, amts(0, 0, 0, 0));
		run_random(450);
		set_totals(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
			8'($urandom_range(0, 40)), 8'($urandom));
		send_request(CMD_RESTART, 0, amts(0, 0, 0, 0));
		run_random(300);
	endtask

	// response side held off while requests keep coming
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (400) @(negedge clk);
				rx_hold = 1'b0;
			end
		join_none
		no_idle = 1'b1;
		run_random(40);
	endtask

	initial begin
		for (int r = 0; r < 4; r++) totals[r] = '0;
		for (int r = 0; r < NRES; r++) avail_units[r] = '0;
		for (int c = 0; c < NCUST; c++)
			for (int r = 0; r < NRES; r++) begin
				alloc_units[c][r] = '0;
				need_units[c][r] = '0;
			end
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_state();
		test_directed();
		test_random_phases();
		test_backpressure();
		if (errors == 0) $display("bankers_resource_manager_unit_tb passed");
		else $display("bankers_resource_manager_unit_tb failed");
		$finish;
	end

endmodule
